// File: hw/rtl/dppe_pkg.sv
// ----------------------------------------------------------------------------
// dppe_pkg - shared definitions for the distinct-part partition enumerator
// Widths, register indexes, sequencer states and the small constant tables.
// ----------------------------------------------------------------------------
package dppe_pkg;

  localparam int MAX_PARTS = 16;
  localparam int MAX_VALUE = 64;

  localparam int PART_W   = 6;   // part value
  localparam int POS_W    = 4;   // part position
  localparam int IDX_W    = 5;   // position counter, can hold MAX_PARTS
  localparam int SUM_W    = 10;  // total sum
  localparam int NPARTS_W = 5;
  localparam int LIMIT_W  = 7;
  localparam int ORD_W    = 16;
  localparam int CFG_W    = 10;
  localparam int NUM_W    = 11;  // dividend of the quotient unit
  localparam int RCP_W    = 16;  // reciprocal scale is 2**RCP_W
  localparam int TRI_W    = 8;

  typedef enum logic [1:0] {
    CFG_TOTAL_SUM  = 2'd0,
    CFG_NUM_PARTS  = 2'd1,
    CFG_PART_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL_MUL,
    ST_FILL_WR,
    ST_EMIT,
    ST_NONE
  } state_t;

  // one refill step: remaining sum to spread over positions pos .. 0
  typedef struct packed {
    logic [SUM_W-1:0] rem;
    logic [POS_W-1:0] pos;
  } fill_req_t;

  // triangular numbers p*(p+1)/2 for p = 0 .. MAX_PARTS
  localparam logic [TRI_W-1:0] TRI [0:MAX_PARTS] = '{
    8'd0,  8'd1,  8'd3,  8'd6,  8'd10, 8'd15, 8'd21, 8'd28, 8'd36,
    8'd45, 8'd55, 8'd66, 8'd78, 8'd91, 8'd105, 8'd120, 8'd136
  };

  // ceil(2**16 / (p+1)), exact floor division for dividends below 2**11;
  // position 0 never divides, its entry is unused
  localparam logic [RCP_W-1:0] RECIP [0:MAX_PARTS-1] = '{
    16'd0,    16'd32768, 16'd21846, 16'd16384, 16'd13108, 16'd10923,
    16'd9363, 16'd8192,  16'd7282,  16'd6554,  16'd5958,  16'd5462,
    16'd5042, 16'd4682,  16'd4370,  16'd4096
  };

endpackage

// File: hw/rtl/distinct_part_partition_enumerator.sv
// ----------------------------------------------------------------------------
// distinct_part_partition_enumerator - walks sets of distinct bounded parts
// Restart: accept, then a ST_FILL_MUL and a ST_FILL_WR step per part refilled,
// then one part a cycle while rsp_stall allows. Next set: a scan up to the part
// that can step, the same steps per refilled position below it, then one output
// word per part; output stalls hold the emit. No set left: one none_left word.
// One word in flight; the refill quotient unit and the part store set the pace.
// Reset clears control, set count, sum and limit, sets num_parts to 1, keeps parts.
// ----------------------------------------------------------------------------
module distinct_part_partition_enumerator import dppe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  // request
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                restart,
  // result
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [PART_W-1:0]   part_value,
  output logic [POS_W-1:0]    part_position,
  output logic                last_part,
  output logic [ORD_W-1:0]    set_ordinal,
  output logic                none_left
);

  state_t state, state_next;

  logic [SUM_W-1:0]    total_sum;
  logic [NPARTS_W-1:0] num_parts;
  logic [LIMIT_W-1:0]  part_limit;
  logic                started;
  logic                exhausted;
  logic [ORD_W-1:0]    set_count;

  logic [PART_W-1:0]   parts [0:MAX_PARTS-1];
  logic [IDX_W-1:0]    idx;
  logic [PART_W-1:0]   prev;
  logic [SUM_W-1:0]    acc;
  logic [SUM_W-1:0]    rem;
  logic [POS_W-1:0]    pos;

  logic [LIMIT_W-1:0]  w_eff;
  logic                n_ok;
  logic [NPARTS_W-1:0] n_hi;
  logic [NPARTS_W-1:0] n_lo;
  logic [11:0]         cap;
  logic [11:0]         need;
  logic                can_start;
  logic [PART_W-1:0]   rd_val;
  logic [POS_W-1:0]    j;
  logic                at_end;
  logic [LIMIT_W-1:0]  top;
  logic [LIMIT_W-1:0]  cand;
  logic [SUM_W-1:0]    floor_sum;
  logic                scan_hit;
  logic                scan_fail;
  logic                last_emit;
  logic [PART_W-1:0]   fill_v;
  fill_req_t           fill_req;

  logic                cfg_write;
  logic                req_accept;
  logic                rsp_load;

  dppe_fill_unit u_fill (
    .clk   (clk),
    .req   (fill_req),
    .value (fill_v)
  );

  assign fill_req.rem = rem;
  assign fill_req.pos = pos;

  // ---------------------------------------------------------------- conditions
  always_comb begin
    w_eff = (part_limit > LIMIT_W'(MAX_VALUE)) ? LIMIT_W'(MAX_VALUE) : part_limit;
    n_ok  = (num_parts != '0) && (num_parts <= NPARTS_W'(MAX_PARTS));
    n_hi  = n_ok ? num_parts : '0;
    n_lo  = n_ok ? (num_parts - NPARTS_W'(1)) : '0;
    // k parts fit when k <= w and T(k-1) <= sum <= k*w - T(k)
    cap   = 12'(num_parts) * 12'(w_eff);
    need  = 12'(total_sum) + 12'(TRI[n_hi]);
    can_start = n_ok && (LIMIT_W'(num_parts) <= w_eff)
                && (total_sum >= SUM_W'(TRI[n_lo])) && (need <= cap);

    rd_val = parts[idx[POS_W-1:0]];
    j      = POS_W'(idx - IDX_W'(1));
    at_end = (idx == IDX_W'(num_parts));
    top    = at_end ? w_eff : LIMIT_W'(rd_val);
    cand   = LIMIT_W'(prev) + LIMIT_W'(1);
    // lower positions must still hold at least T(j-1) after the step
    floor_sum = SUM_W'(prev) + SUM_W'(TRI[{1'b0, POS_W'(j - POS_W'(1))}]);
    scan_hit  = (idx != '0) && (j != '0) && (cand < top) && (acc > floor_sum);
    scan_fail = (idx != '0) && !scan_hit && at_end;

    last_emit = (idx == IDX_W'(num_parts - NPARTS_W'(1)));
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    // a pending register write goes first
    req_stall  = (state != ST_IDLE) || cfg_valid;
    cfg_ready  = (state == ST_IDLE);
    cfg_write  = cfg_valid && cfg_ready;
    req_accept = req_valid && !req_stall;
    rsp_load   = ((state == ST_EMIT) || (state == ST_NONE)) && (!rsp_valid || !rsp_stall);
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_accept) begin
          if (restart) begin
            state_next = can_start ? ST_FILL_MUL : ST_NONE;
          end else begin
            state_next = (started && !exhausted && n_ok) ? ST_SCAN : ST_NONE;
          end
        end
      end
      ST_SCAN: begin
        priority if (scan_hit) begin
          state_next = ST_FILL_MUL;
        end else if (scan_fail) begin
          state_next = ST_NONE;
        end
      end
      ST_FILL_MUL: begin
        state_next = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        state_next = (pos == '0) ? ST_EMIT : ST_FILL_MUL;
      end
      ST_EMIT: begin
        if (rsp_load && last_emit) begin
          state_next = ST_IDLE;
        end
      end
      ST_NONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_sum  <= '0;
      num_parts  <= NPARTS_W'(1);
      part_limit <= '0;
      started    <= 1'b0;
      exhausted  <= 1'b0;
      set_count  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_TOTAL_SUM: begin
            total_sum <= cfg_data[SUM_W-1:0];
            started   <= 1'b0;
            exhausted <= 1'b0;
          end
          CFG_NUM_PARTS: begin
            num_parts <= cfg_data[NPARTS_W-1:0];
            started   <= 1'b0;
            exhausted <= 1'b0;
          end
          CFG_PART_LIMIT: begin
            part_limit <= cfg_data[LIMIT_W-1:0];
            started    <= 1'b0;
            exhausted  <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      if (req_accept && restart) begin
        set_count <= '0;
        exhausted <= 1'b0;
        started   <= 1'b1;
      end

      if ((state == ST_FILL_WR) && (pos == '0) && (set_count != '1)) begin
        set_count <= set_count + ORD_W'(1);
      end

      if ((state == ST_NONE) && rsp_load) begin
        exhausted <= 1'b1;
      end

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_accept) begin
          idx <= '0;
          rem <= total_sum;
          pos <= POS_W'(num_parts - NPARTS_W'(1));
        end
      end
      ST_SCAN: begin
        priority if (idx == '0) begin
          prev <= rd_val;
          acc  <= SUM_W'(rd_val);
          idx  <= IDX_W'(1);
        end else if (scan_hit) begin
          // step part j up by one and refill everything below it
          parts[j] <= cand[PART_W-1:0];
          rem      <= acc - SUM_W'(cand);
          pos      <= j - POS_W'(1);
        end else if (!at_end) begin
          prev <= rd_val;
          acc  <= acc + SUM_W'(rd_val);
          idx  <= idx + IDX_W'(1);
        end
      end
      ST_FILL_MUL: begin
      end
      ST_FILL_WR: begin
        parts[pos] <= fill_v;
        rem        <= rem - SUM_W'(fill_v);
        if (pos == '0) begin
          idx <= '0;
        end else begin
          pos <= pos - POS_W'(1);
        end
      end
      ST_EMIT: begin
        if (rsp_load) begin
          idx <= idx + IDX_W'(1);
        end
      end
      ST_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      if (state == ST_EMIT) begin
        part_value    <= rd_val;
        part_position <= idx[POS_W-1:0];
        last_part     <= last_emit;
        set_ordinal   <= set_count;
        none_left     <= 1'b0;
      end else begin
        part_value    <= '0;
        part_position <= '0;
        last_part     <= 1'b0;
        set_ordinal   <= '0;
        none_left     <= 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/dppe_fill_unit.sv
// ----------------------------------------------------------------------------
// dppe_fill_unit - smallest part for one position of a refill
// Unit that registers the reciprocal product, then gives
// max(pos, ceil((rem + pos*(pos+1)/2) / (pos+1))), or rem itself at position 0.
// ----------------------------------------------------------------------------
module dppe_fill_unit import dppe_pkg::*; (
  input  logic              clk,
  input  fill_req_t         req,
  output logic [PART_W-1:0] value
);

  logic [NUM_W-1:0]       num;
  logic [NUM_W+RCP_W-1:0] prod;
  logic [SUM_W-1:0]       rem_r;
  logic [POS_W-1:0]       pos_r;
  logic [NUM_W-1:0]       quo;

  // ceiling division folded in by adding pos to the dividend
  assign num = NUM_W'(req.rem) + NUM_W'(TRI[{1'b0, req.pos}]) + NUM_W'(req.pos);

  always_ff @(posedge clk) begin
    prod  <= (NUM_W+RCP_W)'(num) * (NUM_W+RCP_W)'(RECIP[req.pos]);
    rem_r <= req.rem;
    pos_r <= req.pos;
  end

  assign quo = prod[NUM_W+RCP_W-1:RCP_W];

  always_comb begin
    if (pos_r == '0) begin
      value = rem_r[PART_W-1:0];
    end else if (quo > NUM_W'(pos_r)) begin
      value = quo[PART_W-1:0];
    end else begin
      value = PART_W'(pos_r);
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for the distinct-part partition enumerator
// A queue-fed driver offers restart/next requests and a clocked monitor checks
// every result word against an in-bench predictor of the enumeration order.
// Registers are rewritten between phases; gaps and stalls vary by phase.
// ----------------------------------------------------------------------------
module tb;
  import dppe_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int STALL_LIMIT  = 4000;  // cycles with nothing accepted
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int RANDOM_ITEMS = 180;
  localparam int SETTLE       = 4;
  localparam int TAIL_CYCLES  = 150;

  localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped register index

  typedef enum int {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_t;

  typedef struct {
    logic [PART_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic [ORD_W-1:0]  ordinal;
    logic              none;
  } part_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic              restart = 1'b0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic [PART_W-1:0] part_value;
  logic [POS_W-1:0]  part_position;
  logic              last_part;
  logic [ORD_W-1:0]  set_ordinal;
  logic              none_left;

  distinct_part_partition_enumerator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .restart       (restart),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .part_value    (part_value),
    .part_position (part_position),
    .last_part     (last_part),
    .set_ordinal   (set_ordinal),
    .none_left     (none_left)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // predictor state
  int         parts_now [MAX_PARTS];
  bit         enum_running;
  bit         enum_done;
  int         sets_given;
  int         want_sum;
  int         want_parts;
  int         want_limit;

  part_word_t expected_words [$];
  part_word_t head_word;
  bit         pending_restart [$];
  int         reqs_pushed;
  int         reqs_accepted;
  bit         req_taken;
  int         quiet_cycles;
  int         err_cnt;
  gap_mode_t  gap_mode = GAP_NONE;
  int         hold_asks;
  int         hold_seen;
  int         hold_left;

  // can k distinct values in 0 .. w-1 reach exactly s
  function automatic bit reachable(int k, int s, int w);
    int lo;
    int hi;
    if (k == 0) return s == 0;
    if (k > w) return 1'b0;
    lo = k * (k - 1) / 2;
    hi = k * (w - 1) - lo;
    return (s >= lo) && (s <= hi);
  endfunction

  // lowest arrangement of positions 0 .. k-1, top position chosen first
  function automatic bit fill_lowest(int k, int s, int w);
    int pos;
    int v;
    if (!reachable(k, s, w)) return 1'b0;
    for (pos = k - 1; pos >= 0; pos--) begin
      for (v = 0; v < w; v++) begin
        if (reachable(pos, s - v, v)) break;
      end
      if (v >= w) return 1'b0;
      parts_now[pos] = v;
      s -= v;
      w = v;
    end
    return 1'b1;
  endfunction

  // bump the lowest position that can move, then refill below it
  function automatic bit next_set(int n, int w);
    int j;
    int i;
    int v;
    int rest;
    int top;
    for (j = 0; j < n; j++) begin
      rest = want_sum;
      for (i = j + 1; i < n; i++) rest -= parts_now[i];
      top = (j == n - 1) ? w : parts_now[j + 1];
      for (v = parts_now[j] + 1; v < top; v++) begin
        if (reachable(j, rest - v, v)) begin
          parts_now[j] = v;
          return fill_lowest(j, rest - v, v);
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_request(bit rs);
    int n;
    int w;
    int k;
    bit ok;
    part_word_t pw;
    n = want_parts;
    w = (want_limit > MAX_VALUE) ? MAX_VALUE : want_limit;
    if (rs) begin
      sets_given = 0;
      enum_done = 1'b0;
      enum_running = 1'b1;
      if (n < 1 || n > MAX_PARTS) begin
        ok = 1'b0;
      end else begin
        foreach (parts_now[i]) parts_now[i] = 0;
        ok = fill_lowest(n, want_sum, w);
      end
    end else if (!enum_running || enum_done || n < 1 || n > MAX_PARTS) begin
      ok = 1'b0;
    end else begin
      ok = next_set(n, w);
    end
    if (!ok) begin
      enum_done = 1'b1;
      pw = '{value: '0, pos: '0, last: 1'b0, ordinal: '0, none: 1'b1};
      expected_words.insert(expected_words.size(), pw);
    end else begin
      if (sets_given < 16'hFFFF) sets_given++;
      for (k = 0; k < n; k++) begin
        pw.value   = parts_now[k][PART_W-1:0];
        pw.pos     = k[POS_W-1:0];
        pw.last    = (k == n - 1);
        pw.ordinal = sets_given[ORD_W-1:0];
        pw.none    = 1'b0;
        expected_words.insert(expected_words.size(), pw);
      end
    end
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_TOTAL_SUM:  want_sum   = int'(val & 10'h3FF);
      CFG_NUM_PARTS:  want_parts = int'(val & 10'h01F);
      CFG_PART_LIMIT: want_limit = int'(val & 10'h07F);
      default: return;  // spare index: no register, enumeration untouched
    endcase
    enum_running = 1'b0;
    enum_done = 1'b0;
  endfunction

  function automatic bit gap_now(bit sender);
    int pct;
    pct = 0;
    case (gap_mode)
      GAP_SENDER:   pct = sender ? 84 : 0;
      GAP_RECEIVER: pct = sender ? 0 : 84;
      GAP_BOTH:     pct = 32;
      default:      pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_taken)) begin
      if (pending_restart.size() != 0 && !gap_now(1'b1)) begin
        req_valid <= 1'b1;
        restart <= pending_restart.pop_front();
      end else begin
        req_valid <= 1'b0;
        restart <= 1'($urandom_range(0, 1));
      end
    end
  end

  // result receiver, with the long hold-off counted here
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= gap_now(1'b0);
    end
  end

  // monitor and predictor hook
  always @(posedge clk) begin
    if (rst) begin
      req_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      req_taken = req_valid && !req_stall;
      if (req_taken) begin
        reqs_accepted++;
        predict_request(restart);
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: part_value %0d none_left %0d", part_value, none_left);
          err_cnt++;
        end else begin
          head_word = expected_words.pop_front();
          if (part_value !== head_word.value) begin
            $error("part_value: expected %0d, got %0d", head_word.value, part_value);
            err_cnt++;
          end
          if (part_position !== head_word.pos) begin
            $error("part_position: expected %0d, got %0d", head_word.pos, part_position);
            err_cnt++;
          end
          if (last_part !== head_word.last) begin
            $error("last_part: expected %0d, got %0d", head_word.last, last_part);
            err_cnt++;
          end
          if (set_ordinal !== head_word.ordinal) begin
            $error("set_ordinal: expected %0d, got %0d", head_word.ordinal, set_ordinal);
            err_cnt++;
          end
          if (none_left !== head_word.none) begin
            $error("none_left: expected %0d, got %0d", head_word.none, none_left);
            err_cnt++;
          end
        end
      end
      if (req_taken || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_index <= 2'($urandom_range(0, 3));
    cfg_data  <= CFG_W'($urandom_range(0, 1023));
  endtask

  // upper bits beyond the register width are junk the block must drop
  function automatic logic [CFG_W-1:0] with_junk(int v, int width);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom_range(0, 1023));
    if ($urandom_range(0, 2) == 0) return CFG_W'(v) | (junk << width);
    return CFG_W'(v);
  endfunction

  task automatic set_config(int s, int n, int w);
    write_reg(CFG_TOTAL_SUM, with_junk(s, SUM_W));
    write_reg(CFG_NUM_PARTS, with_junk(n, NPARTS_W));
    write_reg(CFG_PART_LIMIT, with_junk(w, LIMIT_W));
  endtask

  task automatic send(bit rs);
    pending_restart.insert(pending_restart.size(), rs);
    reqs_pushed++;
  endtask

  task automatic drain();
    while (reqs_accepted != reqs_pushed || expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic random_setting();
    int n;
    int w;
    int lo;
    int hi;
    int s;
    case ($urandom_range(0, 5))
      0: begin
        n = MAX_PARTS;
        w = ($urandom_range(0, 1) == 0) ? $urandom_range(16, 64) : $urandom_range(65, 127);
        s = $urandom_range(0, 1023);
      end
      1: begin
        n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
        w = $urandom_range(0, 127);
        s = $urandom_range(0, 1023);
      end
      default: begin
        n = $urandom_range(1, 4);
        w = $urandom_range(n, 12);
        lo = n * (n - 1) / 2;
        hi = n * (w - 1) - lo;
        s = (hi >= lo) ? $urandom_range(lo, hi) : $urandom_range(0, 20);
      end
    endcase
    set_config(s, n, w);
  endtask

  initial begin
    int sent;
    int target;
    int phase;
    int k;
    want_sum = 0;
    want_parts = 1;
    want_limit = 0;
    enum_running = 1'b0;
    enum_done = 1'b0;
    sets_given = 0;
    foreach (parts_now[i]) parts_now[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // next before any restart, then reset settings admit nothing
    send(1'b0);
    send(1'b1);
    send(1'b0);
    drain();

    // small case run to the end and past it
    set_config(3, 2, 4);
    send(1'b1);
    send(1'b0);
    send(1'b0);
    send(1'b0);
    drain();

    // part limit above the maximum clamps
    set_config(5, 1, 100);
    send(1'b1);
    send(1'b0);
    drain();
    set_config(0, 1, 1);
    send(1'b1);
    drain();

    // widest sets: smallest and largest sums, and one beyond reach
    set_config(120, MAX_PARTS, MAX_VALUE);
    send(1'b1);
    send(1'b0);
    drain();
    write_reg(CFG_TOTAL_SUM, 10'd888);
    send(1'b1);
    drain();
    write_reg(CFG_TOTAL_SUM, 10'd1023);
    send(1'b1);
    drain();

    // part counts out of range
    write_reg(CFG_NUM_PARTS, 10'h020);
    send(1'b1);
    drain();
    write_reg(CFG_NUM_PARTS, 10'd17);
    send(1'b1);
    drain();
    write_reg(CFG_NUM_PARTS, 10'd31);
    send(1'b1);
    drain();

    // spare index leaves the run alone; a real write abandons it
    set_config(10, 3, 8);
    send(1'b1);
    send(1'b0);
    drain();
    write_reg(CFG_SPARE, 10'h3FF);
    send(1'b0);
    drain();
    write_reg(CFG_TOTAL_SUM, 10'd10);
    send(1'b0);
    send(1'b1);
    send(1'b0);
    drain();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      gap_mode = gap_mode_t'(phase % 4);
      random_setting();
      if (phase == 2) begin
        // back-pressure: results held off while requests keep coming
        gap_mode = GAP_NONE;
        hold_asks++;
      end
      target = $urandom_range(14, 26);
      k = 0;
      while (k < target) begin
        if ($urandom_range(0, 9) == 0) begin
          send(1'b0);
          k++;
        end
        send(1'b1);
        k++;
        repeat ($urandom_range(2, 12)) begin
          send($urandom_range(0, 11) == 0);
          k++;
        end
      end
      sent += k;
      drain();
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      err_cnt++;
    end
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
